@@ sv/esrs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esrs_pkg
// Shared constants, codes and types of the emulated sector read splitter.
// ----------------------------------------------------------------------------
package esrs_pkg;

    // Emulated sectors per backing block (a power of two) and request count width.
    localparam int SECTORS_PER_BLOCK = 4;
    localparam int COUNT_BITS        = 16;

    localparam int SPB_LOG2 = $clog2(SECTORS_PER_BLOCK);
    localparam int LEAD_W   = SPB_LOG2 + 1;

    // Counts are taken modulo 2^COUNT_BITS.
    localparam logic [15:0] CNT_MASK = (COUNT_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << COUNT_BITS) - 32'd1);

    // Request kinds.
    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_FORMAT = 3'd2;
    localparam logic [2:0] KIND_VERIFY = 3'd3;
    localparam logic [2:0] KIND_RESET  = 3'd4;
    localparam logic [2:0] KIND_SEEK   = 3'd5;
    localparam logic [2:0] KIND_READY  = 3'd6;
    localparam logic [2:0] KIND_OTHER  = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_WPROT    = 2'd1;
    localparam logic [1:0] STATUS_BADPARAM = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_BASE = 1'b0;
    localparam logic CFG_EMU_ENABLE = 1'b1;

    // Request as held in the input register.
    typedef struct packed {
        logic [2:0]          kind;
        logic [31:0]         blba0;
        logic [SPB_LOG2-1:0] off;
        logic [15:0]         count;
    } req_t;

    // One result descriptor.
    typedef struct packed {
        logic        has_read;
        logic [31:0] block_lba;
        logic [14:0] block_count;
        logic        staged;
        logic [1:0]  copy_offset;
        logic [1:0]  copy_sectors;
        logic [15:0] dest_offset;
        logic [15:0] done_count;
        logic [1:0]  status;
    } desc_t;

    // Descriptor selected for the current slot, with its end-of-request mark.
    typedef struct packed {
        desc_t desc;
        logic  last;
    } plan_t;

endpackage : esrs_pkg
`default_nettype wire

@@ sv/esrs_plan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esrs_plan
// Splits the registered request into leading, whole-block and trailing reads
// and selects the descriptor for the given output slot.
// ----------------------------------------------------------------------------
module esrs_plan
    import esrs_pkg::*;
(
    input  wire req_t       req,
    input  wire logic       emu_en,
    input  wire logic [1:0] idx,
    output plan_t           plan
);

    localparam logic [15:0] SUB_MASK = 16'(SECTORS_PER_BLOCK - 1);

    logic              lead_has;
    logic              mid_has;
    logic              tail_has;
    logic [LEAD_W-1:0] avail;
    logic [15:0]       lead_n;
    logic [15:0]       rem;
    logic [15:0]       mid_n;
    logic [15:0]       rem_al;
    logic [15:0]       tail_n;
    logic [16:0]       skip_blocks;
    logic [31:0]       blba_mid;
    logic [31:0]       blba_tail;
    logic [1:0]        n_read;
    logic [1:0]        last_idx;
    desc_t             lead_d;
    desc_t             mid_d;
    desc_t             tail_d;
    desc_t             none_d;
    desc_t             read_sel;

    assign lead_has = (req.off != '0);
    assign avail    = LEAD_W'(SECTORS_PER_BLOCK) - LEAD_W'(req.off);

    always_comb begin
        if (!lead_has) begin
            lead_n = '0;
        end else if (16'(avail) > req.count) begin
            lead_n = req.count;
        end else begin
            lead_n = 16'(avail);
        end
    end

    assign rem         = req.count - lead_n;
    assign mid_n       = rem >> SPB_LOG2;
    assign mid_has     = (mid_n != '0);
    assign rem_al      = rem & ~SUB_MASK;
    assign tail_n      = rem & SUB_MASK;
    assign tail_has    = (tail_n != '0);
    assign skip_blocks = 17'(mid_n) + 17'(lead_has);
    assign blba_mid    = req.blba0 + 32'(lead_has);
    assign blba_tail   = req.blba0 + 32'(skip_blocks);

    always_comb begin
        lead_d              = '0;
        lead_d.has_read     = 1'b1;
        lead_d.block_lba    = req.blba0;
        lead_d.block_count  = 15'd1;
        lead_d.staged       = 1'b1;
        lead_d.copy_offset  = 2'(req.off);
        lead_d.copy_sectors = 2'(lead_n);
        lead_d.done_count   = lead_n;
        lead_d.status       = STATUS_OK;

        mid_d               = '0;
        mid_d.has_read      = 1'b1;
        mid_d.block_lba     = blba_mid;
        mid_d.block_count   = 15'(mid_n);
        mid_d.dest_offset   = lead_n;
        mid_d.done_count    = lead_n + rem_al;
        mid_d.status        = STATUS_OK;

        tail_d              = '0;
        tail_d.has_read     = 1'b1;
        tail_d.block_lba    = blba_tail;
        tail_d.block_count  = 15'd1;
        tail_d.staged       = 1'b1;
        tail_d.copy_sectors = 2'(tail_n);
        tail_d.dest_offset  = lead_n + rem_al;
        tail_d.done_count   = req.count;
        tail_d.status       = STATUS_OK;
    end

    assign n_read = 2'(lead_has) + 2'(mid_has) + 2'(tail_has);

    // Present reads are packed into consecutive slots in request order.
    always_comb begin
        case (idx)
            2'd0: begin
                if (lead_has) begin
                    read_sel = lead_d;
                end else if (mid_has) begin
                    read_sel = mid_d;
                end else begin
                    read_sel = tail_d;
                end
            end
            2'd1: begin
                if (lead_has && mid_has) begin
                    read_sel = mid_d;
                end else begin
                    read_sel = tail_d;
                end
            end
            default: begin
                read_sel = tail_d;
            end
        endcase
    end

    always_comb begin
        none_d = '0;
        if (!emu_en) begin
            none_d.status     = STATUS_OK;
            none_d.done_count = req.count;
        end else begin
            unique case (req.kind) inside
                KIND_READ: begin
                    none_d.status     = STATUS_OK;
                    none_d.done_count = '0;
                end
                KIND_WRITE, KIND_FORMAT: begin
                    none_d.status     = STATUS_WPROT;
                    none_d.done_count = req.count;
                end
                KIND_VERIFY, KIND_RESET, KIND_SEEK, KIND_READY: begin
                    none_d.status     = STATUS_OK;
                    none_d.done_count = req.count;
                end
                KIND_OTHER: begin
                    none_d.status     = STATUS_BADPARAM;
                    none_d.done_count = '0;
                end
            endcase
        end
    end

    always_comb begin
        if (emu_en && (req.kind == KIND_READ) && (n_read != 2'd0)) begin
            plan.desc = read_sel;
            last_idx  = n_read - 2'd1;
        end else begin
            plan.desc = none_d;
            last_idx  = 2'd0;
        end
        plan.last = (idx == last_idx);
    end

endmodule : esrs_plan
`default_nettype wire

@@ sv/esrs_obuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esrs_obuf
// Result register of the splitter: holds one descriptor until it is taken.
// ----------------------------------------------------------------------------
module esrs_obuf
    import esrs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire plan_t       plan,
    output logic             space,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // block_lba[31:0], block_count[46:32], staged[47], copy_offset[49:48],
    // copy_sectors[51:50], dest_offset[67:52], done_count[83:68],
    // status[85:84], zero padding[87:86]
    output logic [87:0]      m_tdata,
    // has_read[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    logic        valid_reg;
    logic        valid_next;
    logic [87:0] data_reg;
    logic [87:0] data_next;
    logic        user_reg;
    logic        user_next;
    logic        last_reg;
    logic        last_next;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {2'b00,
                          plan.desc.status,
                          plan.desc.done_count,
                          plan.desc.dest_offset,
                          plan.desc.copy_sectors,
                          plan.desc.copy_offset,
                          plan.desc.staged,
                          plan.desc.block_count,
                          plan.desc.block_lba};
            user_next  = plan.desc.has_read;
            last_next  = plan.last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule : esrs_obuf
`default_nettype wire

@@ sv/emulated_sector_read_splitter.sv @@
`default_nettype none
// A request is held in the request register; each result it yields is registered
// in the single result register, and results leave at one per cycle while the
// receiver does not stall. A request yields 1 to 3 descriptors; the next request
// is taken in the cycle its predecessor's last descriptor enters the result register.
// Reset (aresetn low at a clock edge) empties both registers, sets image_base_lba to 0
// and emulation_enable to 1.
// ----------------------------------------------------------------------------
// emulated_sector_read_splitter
// Turns 512-byte sector disk requests into 2048-byte backing block reads.
// ----------------------------------------------------------------------------
module emulated_sector_read_splitter
    import esrs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    // Requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sector_lba[31:0], num_sectors[47:32]
    input  wire logic [47:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_tuser,
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // block_lba[31:0], block_count[46:32], staged[47], copy_offset[49:48],
    // copy_sectors[51:50], dest_offset[67:52], done_count[83:68],
    // status[85:84], zero padding[87:86]
    output logic [87:0]      m_tdata,
    // has_read[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [31:0] base_reg;
    logic [31:0] base_next;
    logic        enable_reg;
    logic        enable_next;
    logic        req_valid_reg;
    logic        req_valid_next;
    req_t        req_reg;
    req_t        req_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;

    logic        cfg_wr;
    logic        s_acc;
    logic        space;
    logic        load;
    logic        req_done;
    plan_t       plan;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        base_next   = base_reg;
        enable_next = enable_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                CFG_IMAGE_BASE: base_next   = cfg_data;
                CFG_EMU_ENABLE: enable_next = cfg_data[0];
            endcase
        end
    end

    esrs_plan u_plan (
        .req    (req_reg),
        .emu_en (enable_reg),
        .idx    (idx_reg),
        .plan   (plan)
    );

    esrs_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .plan     (plan),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign load     = req_valid_reg && space;
    assign req_done = load && plan.last;
    assign s_tready = !req_valid_reg || req_done;
    assign s_acc    = s_tvalid && s_tready;

    // The image base is folded into the block address as the request is taken.
    always_comb begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        if (s_acc) begin
            req_valid_next = 1'b1;
            req_next.kind  = s_tuser;
            req_next.blba0 = base_reg + (s_tdata[31:0] >> SPB_LOG2);
            req_next.off   = s_tdata[SPB_LOG2-1:0];
            req_next.count = s_tdata[47:32] & CNT_MASK;
            idx_next       = 2'd0;
        end else if (req_done) begin
            req_valid_next = 1'b0;
        end else if (load) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            enable_reg    <= 1'b1;
            req_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            base_reg      <= base_next;
            enable_reg    <= enable_next;
            req_valid_reg <= req_valid_next;
            idx_reg       <= idx_next;
        end
        req_reg <= req_next;
    end

`ifndef SYNTHESIS
    // A request never advances past its third descriptor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg |-> (idx_reg != 2'd3))
        else $error("descriptor slot index out of range");

    // A stalled result register holds back both the request and new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while result stalled");

    // A status-only result always ends its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("status result without last mark");

    // A held request with room in the result register loads a descriptor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && !(m_tvalid && !m_tready)) |=> m_tvalid)
        else $error("result missing after request");
`endif

endmodule : emulated_sector_read_splitter
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the emulated sector read splitter. Disk requests go
// in through a randomly paced sender while a randomly stalling receiver takes
// the read descriptors. Each descriptor is checked against a local prediction
// built from the current image base and emulation enable settings.
// ----------------------------------------------------------------------------
module tb_top;
    import esrs_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector_lba;
        logic [15:0] num_sectors;
    } disk_req_t;

    typedef struct packed {
        logic        has_read;
        logic [31:0] block_lba;
        logic [14:0] block_count;
        logic        staged;
        logic [1:0]  copy_offset;
        logic [1:0]  copy_sectors;
        logic [15:0] dest_offset;
        logic [15:0] done_count;
        logic [1:0]  status;
        logic        last;
    } sector_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_IMAGE_BASE;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = KIND_READ;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    disk_req_t      pending_reqs[$];
    sector_result_t expected_results[$];

    logic [31:0] image_base_copy = '0;
    logic        emu_enable_copy = 1'b1;
    logic        req_fire        = 1'b0;
    logic        full_rate       = 1'b0;
    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;
    int unsigned hold_left       = 0;
    bit          hold_done       = 1'b0;
    int unsigned results_seen    = 0;
    int unsigned mismatches      = 0;
    disk_req_t   next_req;

    emulated_sector_read_splitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none during a full-rate stretch.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Splits one request into its expected descriptors.
    task automatic predict_request(input disk_req_t req);
        sector_result_t parts[3];
        sector_result_t r;
        logic [31:0]    blba;
        int unsigned    remaining, off, n, done, k;
        remaining = req.num_sectors & CNT_MASK;
        done = 0;
        k = 0;
        r = '0;
        if (!emu_enable_copy) begin
            r.done_count = remaining[15:0];
            r.status = STATUS_OK;
        end else if (req.kind == KIND_WRITE || req.kind == KIND_FORMAT) begin
            r.done_count = remaining[15:0];
            r.status = STATUS_WPROT;
        end else if (req.kind == KIND_VERIFY || req.kind == KIND_RESET ||
                     req.kind == KIND_SEEK || req.kind == KIND_READY) begin
            r.done_count = remaining[15:0];
            r.status = STATUS_OK;
        end else if (req.kind != KIND_READ) begin
            r.status = STATUS_BADPARAM;
        end else begin
            blba = image_base_copy + req.sector_lba / SECTORS_PER_BLOCK;
            off = req.sector_lba % SECTORS_PER_BLOCK;
            // An unaligned start always reads the leading block, even for zero sectors.
            if (off != 0) begin
                n = SECTORS_PER_BLOCK - off;
                if (n > remaining)
                    n = remaining;
                remaining -= n;
                parts[k] = '0;
                parts[k].has_read = 1'b1;
                parts[k].block_lba = blba;
                parts[k].block_count = 15'd1;
                parts[k].staged = 1'b1;
                parts[k].copy_offset = off[1:0];
                parts[k].copy_sectors = n[1:0];
                parts[k].done_count = n[15:0];
                k++;
                done = n;
                blba = blba + 32'd1;
            end
            if (remaining >= SECTORS_PER_BLOCK) begin
                n = remaining / SECTORS_PER_BLOCK;
                parts[k] = '0;
                parts[k].has_read = 1'b1;
                parts[k].block_lba = blba;
                parts[k].block_count = n[14:0];
                parts[k].dest_offset = done[15:0];
                parts[k].done_count = 16'(done + n * SECTORS_PER_BLOCK);
                k++;
                done += n * SECTORS_PER_BLOCK;
                remaining -= n * SECTORS_PER_BLOCK;
                blba = blba + n;
            end
            if (remaining != 0) begin
                parts[k] = '0;
                parts[k].has_read = 1'b1;
                parts[k].block_lba = blba;
                parts[k].block_count = 15'd1;
                parts[k].staged = 1'b1;
                parts[k].copy_sectors = remaining[1:0];
                parts[k].dest_offset = done[15:0];
                parts[k].done_count = 16'(done + remaining);
                k++;
            end
        end
        if (k == 0) begin
            parts[0] = r;
            k = 1;
        end
        parts[k - 1].last = 1'b1;
        for (int i = 0; i < k; i++)
            expected_results.push_back(parts[i]);
    endtask

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Samples every handshake at the rising edge.
    always @(posedge aclk) begin
        sector_result_t want;
        req_fire <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            image_base_copy = '0;
            emu_enable_copy = 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IMAGE_BASE)
                    image_base_copy = cfg_data;
                else
                    emu_enable_copy = cfg_data[0];
            end
            if (s_tvalid && s_tready)
                predict_request({s_tuser, s_tdata[31:0], s_tdata[47:32]});
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: tdata 0x%0h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("has_read", want.has_read, m_tuser);
                    check_field("block_lba", want.block_lba, m_tdata[31:0]);
                    check_field("block_count", want.block_count, m_tdata[46:32]);
                    check_field("staged", want.staged, m_tdata[47]);
                    check_field("copy_offset", want.copy_offset, m_tdata[49:48]);
                    check_field("copy_sectors", want.copy_sectors, m_tdata[51:50]);
                    check_field("dest_offset", want.dest_offset, m_tdata[67:52]);
                    check_field("done_count", want.done_count, m_tdata[83:68]);
                    check_field("status", want.status, m_tdata[85:84]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    // Request sender: holds an item until it is taken, then waits a random gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (req_fire)
                send_gap = pick_gap();
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {next_req.num_sectors, next_req.sector_lba};
                s_tuser <= next_req.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. Once, well into the run, it stops taking items for a long
    // stretch so that the splitter backs up into the request side.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= 80) begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    task automatic add_request(input logic [2:0] kind, input logic [31:0] lba,
                               input logic [15:0] count);
        disk_req_t req;
        req.kind = kind;
        req.sector_lba = lba;
        req.num_sectors = count;
        pending_reqs.push_back(req);
    endtask

    // Mostly reads with small counts; full-width counts now and then.
    task automatic add_random_requests(input int unsigned num);
        logic [2:0]  kind;
        logic [15:0] count;
        int unsigned r;
        for (int i = 0; i < num; i++) begin
            kind = ($urandom_range(0, 9) < 7) ? KIND_READ : 3'($urandom_range(1, 7));
            r = $urandom_range(0, 9);
            if (r < 4)
                count = 16'($urandom_range(0, 12));
            else if (r < 7)
                count = 16'($urandom_range(0, 200));
            else
                count = 16'($urandom_range(0, 65535));
            add_request(kind, $urandom(), count);
        end
    endtask

    // Returns once every request has gone in and every descriptor has come out.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: base zero, emulation on.
        add_request(KIND_READ, 32'd0, 16'd0);
        add_request(KIND_READ, 32'd1, 16'd0);
        add_request(KIND_READ, 32'd3, 16'd0);
        add_request(KIND_READ, 32'd0, 16'd1);
        add_request(KIND_READ, 32'd0, 16'd4);
        add_request(KIND_READ, 32'd0, 16'd7);
        add_request(KIND_READ, 32'd1, 16'd2);
        add_request(KIND_READ, 32'd2, 16'd2);
        add_request(KIND_READ, 32'd3, 16'd9);
        add_request(KIND_READ, 32'd5, 16'hFFFF);
        add_request(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF);
        add_request(KIND_READ, 32'hFFFF_FFFC, 16'd8);
        add_request(KIND_WRITE, 32'd100, 16'd5);
        add_request(KIND_FORMAT, 32'd0, 16'hFFFF);
        add_request(KIND_VERIFY, 32'd7, 16'd3);
        add_request(KIND_RESET, 32'd0, 16'd0);
        add_request(KIND_SEEK, 32'hFFFF_FFFF, 16'd1);
        add_request(KIND_READY, 32'd0, 16'd2);
        add_request(KIND_OTHER, 32'd12, 16'd34);
        drain();

        // The top base makes block addresses wrap.
        write_reg(CFG_IMAGE_BASE, 32'hFFFF_FFFF);
        add_request(KIND_READ, 32'd0, 16'd8);
        add_request(KIND_READ, 32'd6, 16'd3);
        add_request(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF);
        drain();

        write_reg(CFG_EMU_ENABLE, 32'd0);
        add_request(KIND_READ, 32'd1, 16'd10);
        add_request(KIND_WRITE, 32'd0, 16'd1);
        add_request(KIND_OTHER, 32'd0, 16'd7);
        drain();

        write_reg(CFG_EMU_ENABLE, 32'd1);
        write_reg(CFG_IMAGE_BASE, 32'h8000_0000);
        add_random_requests(65);
        drain();

        full_rate = 1'b1;
        write_reg(CFG_IMAGE_BASE, $urandom());
        add_random_requests(65);
        drain();
        full_rate = 1'b0;

        write_reg(CFG_EMU_ENABLE, 32'd0);
        add_random_requests(30);
        drain();

        write_reg(CFG_EMU_ENABLE, 32'd1);
        write_reg(CFG_IMAGE_BASE, 32'd0);
        add_random_requests(60);
        drain();

        write_reg(CFG_IMAGE_BASE, 32'hFFFF_FFFF);
        add_random_requests(65);
        drain();
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
sv/esrs_pkg.sv
sv/esrs_plan.sv
sv/esrs_obuf.sv
sv/emulated_sector_read_splitter.sv
bench/tb_top.sv
